// ----- rtl/core/rect_displacement_warp_assert.svh -----
// Assertion macros shared by the warp block.
`ifndef RECT_DISPLACEMENT_WARP_ASSERT_SVH
`define RECT_DISPLACEMENT_WARP_ASSERT_SVH

// Same-cycle implication, sampled on clk and quiet during rst.
`define RDW_ASSERT_IMPL(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) \
    else $error("rect_displacement_warp: same-cycle check failed");

// Next-cycle implication, sampled on clk and quiet during rst.
`define RDW_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) \
    else $error("rect_displacement_warp: next-cycle check failed");

`endif

// ----- rtl/core/rdw_pkg.sv -----
// ----------------------------------------------------------------------------
// rdw_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package rdw_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_FRAC_BITS  = 8;

  localparam int DIM_W      = 13;
  localparam int OFS_W      = 20;
  localparam int DELTA_W    = 13;
  localparam int PIX_W      = 32;
  localparam int PERS_W     = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [PERS_W-1:0] PERS_ONE = 17'd65536;
  localparam logic signed [OFS_W-1:0] OFS_MAX = 20'sh7FFFF;
  localparam logic signed [OFS_W-1:0] OFS_MIN = -20'sh80000;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PERSIST = 3'd4;

  localparam logic [8:0]        RST_WIDTH   = 9'd256;
  localparam logic [8:0]        RST_HEIGHT  = 9'd256;
  localparam logic [PERS_W-1:0] RST_PERSIST = 17'd62259;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_RECT   = 2'd1;
  localparam logic [1:0] OP_RENDER = 2'd2;

  typedef struct packed {
    logic latch_in;
    logic start_pos;
    logic latch_pos;
    logic clr_wr;
    logic frame_wr;
    logic map_rd_cell;
    logic map_wr_cell;
    logic mul;
    logic dec;
    logic push;
  } rdw_cmd_t;

  typedef struct packed {
    logic       mod_done;
    logic       clr_last;
    logic       cell_last;
    logic       rect_skip;
    logic       out_free;
    logic [1:0] op;
  } rdw_status_t;

endpackage

// ----- rtl/core/rect_displacement_warp.sv -----
// ----------------------------------------------------------------------------
// rect_displacement_warp
// Source frame warped through a decaying per-pixel displacement map.
// ----------------------------------------------------------------------------
// Requests arrive on in_valid/in_stall and carry op with its fields: load
// writes one source pixel, add-rectangle adds delta_x/delta_y over a wrapped
// rectangle, render decays one map entry and returns a displaced pixel on
// out_valid/out_stall. Only render produces a result.
// Each request is handled alone. Its position is first wrapped by bit-serial
// units, one remainder bit per cycle over T = max(9+F, 20) + 1 - F bits (13
// with eight fraction bits). A load then writes its pixel, a rectangle reads
// and writes back each covered cell in turn, and a render reads, decays and
// writes back its map entry, wraps the displaced coordinate and shows pixel_out.
// After reset the block sweeps the offset map to zero, one entry per cycle,
// over MAX_WIDTH*MAX_HEIGHT entries (65536 by default), and holds in_stall high
// meanwhile; configuration writes are taken at any time.
// A stalled result waits in the output register while new requests are still
// taken; a later render holds in its final step until that register is free.
// ----------------------------------------------------------------------------
module rect_displacement_warp #(
  parameter int MAX_WIDTH        = rdw_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT       = rdw_pkg::DEF_MAX_HEIGHT,
  parameter int OFFSET_FRAC_BITS = rdw_pkg::DEF_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rdw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rdw_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          op,
  input  logic [7:0]                          x_pos,
  input  logic [7:0]                          y_pos,
  input  logic [rdw_pkg::PIX_W-1:0]           pixel_in,
  input  logic [7:0]                          rect_left,
  input  logic [7:0]                          rect_top,
  input  logic [7:0]                          rect_right,
  input  logic [7:0]                          rect_bottom,
  input  logic signed [rdw_pkg::DELTA_W-1:0]  delta_x,
  input  logic signed [rdw_pkg::DELTA_W-1:0]  delta_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rdw_pkg::PIX_W-1:0]           pixel_out
);

  rdw_pkg::rdw_cmd_t    cmd;
  rdw_pkg::rdw_status_t status;

  // The controller sequences each request; the datapath holds all storage.
  rdw_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .status(status), .cmd(cmd)
  );

  rdw_datapath #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .OFFSET_FRAC_BITS(OFFSET_FRAC_BITS)
  ) u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .op(op), .x_pos(x_pos), .y_pos(y_pos), .pixel_in(pixel_in),
    .rect_left(rect_left), .rect_top(rect_top),
    .rect_right(rect_right), .rect_bottom(rect_bottom),
    .delta_x(delta_x), .delta_y(delta_y),
    .pixel_out(pixel_out), .out_valid(out_valid), .out_stall(out_stall),
    .cmd(cmd), .status(status)
  );

`include "rect_displacement_warp_assert.svh"

  // An accepted request keeps the block busy on the following cycle.
  `RDW_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // Only a render request pushes a result.
  `RDW_ASSERT_IMPL(a_push_is_render, cmd.push, status.op == rdw_pkg::OP_RENDER)
  // A push never overwrites a result that is still stalled.
  `RDW_ASSERT_IMPL(a_push_into_free, cmd.push, status.out_free)

endmodule

// ----- rtl/core/rdw_mod_unit.sv -----
// ----------------------------------------------------------------------------
// rdw_mod_unit
// Bit-serial restoring remainder of a signed magnitude by the frame size.
// ----------------------------------------------------------------------------
module rdw_mod_unit #(
  parameter int TW = 13
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [TW-1:0]            a,
  input  logic                     neg,
  input  logic [rdw_pkg::DIM_W-1:0] m,
  output logic                     busy,
  output logic [rdw_pkg::DIM_W-1:0] rem
);

  localparam int CNTW = $clog2(TW + 1);

  logic [TW-1:0]               a_sh;
  logic [rdw_pkg::DIM_W-1:0]   r;
  logic                        neg_q;
  logic [CNTW-1:0]             cnt;
  logic [rdw_pkg::DIM_W:0]     rs;
  logic [rdw_pkg::DIM_W:0]     diff;
  logic [rdw_pkg::DIM_W-1:0]   r_next;

  assign rs     = {r, a_sh[TW-1]};
  assign diff   = rs - {1'b0, m};
  assign r_next = (rs >= {1'b0, m}) ? diff[rdw_pkg::DIM_W-1:0] : rs[rdw_pkg::DIM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNTW'(TW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNTW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh  <= a;
      r     <= '0;
      neg_q <= neg;
    end else if (busy) begin
      a_sh <= a_sh << 1;
      r    <= r_next;
    end
  end

  // A negative dividend folds its nonzero remainder back into [0, m).
  assign rem = (neg_q && (r != '0)) ? (m - r) : r;

endmodule

// ----- rtl/core/rdw_datapath.sv -----
// ----------------------------------------------------------------------------
// rdw_datapath
// Configuration, frame and offset memories, decay multiply and wrap units.
// ----------------------------------------------------------------------------
module rdw_datapath #(
  parameter int MAX_WIDTH        = rdw_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT       = rdw_pkg::DEF_MAX_HEIGHT,
  parameter int OFFSET_FRAC_BITS = rdw_pkg::DEF_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rdw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rdw_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [1:0]                          op,
  input  logic [7:0]                          x_pos,
  input  logic [7:0]                          y_pos,
  input  logic [rdw_pkg::PIX_W-1:0]           pixel_in,
  input  logic [7:0]                          rect_left,
  input  logic [7:0]                          rect_top,
  input  logic [7:0]                          rect_right,
  input  logic [7:0]                          rect_bottom,
  input  logic signed [rdw_pkg::DELTA_W-1:0]  delta_x,
  input  logic signed [rdw_pkg::DELTA_W-1:0]  delta_y,
  output logic [rdw_pkg::PIX_W-1:0]           pixel_out,
  output logic                                out_valid,
  input  logic                                out_stall,
  input  rdw_pkg::rdw_cmd_t                   cmd,
  output rdw_pkg::rdw_status_t                status
);

  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int F     = OFFSET_FRAC_BITS;
  localparam int CW    = (((9 + F) > rdw_pkg::OFS_W) ? (9 + F) : rdw_pkg::OFS_W) + 1;
  localparam int TW    = CW - F;
  localparam int OW    = rdw_pkg::OFS_W;
  localparam int DW    = rdw_pkg::DIM_W;
  localparam int PW    = OW + rdw_pkg::PERS_W;

  function automatic logic [AW-1:0] addr_of(input logic [XW-1:0] ax, input logic [YW-1:0] ay);
    addr_of = AW'(AW'(ay) * AW'(MAX_WIDTH) + AW'(ax));
  endfunction

  function automatic logic signed [OW-1:0] sat_add(input logic signed [OW-1:0] a,
                                                   input logic signed [rdw_pkg::DELTA_W-1:0] d);
    logic signed [OW:0] s;
    s = (OW + 1)'(a) + (OW + 1)'(d);
    if (s > (OW + 1)'(rdw_pkg::OFS_MAX)) sat_add = rdw_pkg::OFS_MAX;
    else if (s < (OW + 1)'(rdw_pkg::OFS_MIN)) sat_add = rdw_pkg::OFS_MIN;
    else sat_add = s[OW-1:0];
  endfunction

  // Configuration registers.
  logic [8:0]                  fw, fh;
  logic                        en_clr, en_rect;
  logic [rdw_pkg::PERS_W-1:0]  pers;

  always_ff @(posedge clk) begin
    if (rst) begin
      fw      <= rdw_pkg::RST_WIDTH;
      fh      <= rdw_pkg::RST_HEIGHT;
      en_clr  <= 1'b0;
      en_rect <= 1'b1;
      pers    <= rdw_pkg::RST_PERSIST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rdw_pkg::REG_WIDTH:   fw      <= cfg_data[8:0];
        rdw_pkg::REG_HEIGHT:  fh      <= cfg_data[8:0];
        rdw_pkg::REG_CLEAR:   en_clr  <= cfg_data[0];
        rdw_pkg::REG_RECT:    en_rect <= cfg_data[0];
        rdw_pkg::REG_PERSIST: pers    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [DW-1:0]              w_eff, h_eff;
  logic [rdw_pkg::PERS_W-1:0] p_eff;

  assign w_eff = (fw == '0) ? DW'(1) : ((DW'(fw) > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : DW'(fw));
  assign h_eff = (fh == '0) ? DW'(1) :
                 ((DW'(fh) > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : DW'(fh));
  assign p_eff = (pers > rdw_pkg::PERS_ONE) ? rdw_pkg::PERS_ONE : pers;

  // Request capture.
  logic [1:0]                         op_q;
  logic [7:0]                         xp_q, yp_q, left_q, top_q, rw_q, rh_q;
  logic [rdw_pkg::PIX_W-1:0]          pix_q;
  logic signed [rdw_pkg::DELTA_W-1:0] dx_q, dy_q;
  logic                               skip_q;

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_q   <= op;
      xp_q   <= x_pos;
      yp_q   <= y_pos;
      pix_q  <= pixel_in;
      left_q <= rect_left;
      top_q  <= rect_top;
      rw_q   <= rect_right - rect_left;
      rh_q   <= rect_bottom - rect_top;
      dx_q   <= delta_x;
      dy_q   <= delta_y;
      skip_q <= !en_rect || (rect_right <= rect_left) || (rect_bottom <= rect_top);
    end
  end

  // Wrap units, shared by the position and the displaced coordinate.
  logic [TW-1:0] ax, ay, cmag_x, cmag_y;
  logic          nx, ny, cneg_x, cneg_y, busy_x, busy_y, mstart;
  logic [DW-1:0] remx, remy;
  logic [XW-1:0] rx;
  logic [YW-1:0] ry;

  assign mstart = cmd.start_pos | cmd.dec;
  assign ax = cmd.dec ? cmag_x : TW'((op_q == rdw_pkg::OP_RECT) ? left_q : xp_q);
  assign ay = cmd.dec ? cmag_y : TW'((op_q == rdw_pkg::OP_RECT) ? top_q : yp_q);
  assign nx = cmd.dec & cneg_x;
  assign ny = cmd.dec & cneg_y;

  rdw_mod_unit #(.TW(TW)) u_mod_x (
    .clk(clk), .rst(rst), .start(mstart), .a(ax), .neg(nx), .m(w_eff),
    .busy(busy_x), .rem(remx)
  );

  rdw_mod_unit #(.TW(TW)) u_mod_y (
    .clk(clk), .rst(rst), .start(mstart), .a(ay), .neg(ny), .m(h_eff),
    .busy(busy_y), .rem(remy)
  );

  assign rx = remx[XW-1:0];
  assign ry = remy[YW-1:0];

  // Wrapped position and rectangle walk.
  logic [XW-1:0] px_q, sx_q, cx;
  logic [YW-1:0] py_q, cy;
  logic [AW-1:0] idx_q, cell_addr;
  logic [7:0]    ccnt, rcnt;
  logic          col_last, row_last;

  assign cell_addr = addr_of(cx, cy);
  assign col_last  = (ccnt == rw_q - 8'd1);
  assign row_last  = (rcnt == rh_q - 8'd1);

  always_ff @(posedge clk) begin
    if (cmd.latch_pos) begin
      px_q  <= rx;
      py_q  <= ry;
      idx_q <= addr_of(rx, ry);
      sx_q  <= rx;
      cx    <= rx;
      cy    <= ry;
      ccnt  <= '0;
      rcnt  <= '0;
    end else if (cmd.map_wr_cell) begin
      if (col_last) begin
        cx   <= sx_q;
        ccnt <= '0;
        rcnt <= rcnt + 8'd1;
        cy   <= (DW'(cy) + DW'(1) == h_eff) ? '0 : cy + YW'(1);
      end else begin
        cx   <= (DW'(cx) + DW'(1) == w_eff) ? '0 : cx + XW'(1);
        ccnt <= ccnt + 8'd1;
      end
    end
  end

  // Offset map, x in the upper half of each word.
  logic [2*OW-1:0] map_mem [DEPTH];
  logic [2*OW-1:0] map_q, map_wd;
  logic [AW-1:0]   map_ra, map_wa, clr_cnt;
  logic            map_we;
  logic signed [OW-1:0] ex, ey;

  assign map_ra = cmd.map_rd_cell ? cell_addr : idx_q;
  assign map_we = cmd.clr_wr | cmd.map_wr_cell | cmd.dec;
  assign map_wa = cmd.clr_wr ? clr_cnt : (cmd.map_wr_cell ? cell_addr : idx_q);

  always_comb begin
    if (cmd.clr_wr) map_wd = '0;
    else if (cmd.map_wr_cell) map_wd = {sat_add(map_q[2*OW-1:OW], dx_q),
                                         sat_add(map_q[OW-1:0], dy_q)};
    else map_wd = {ex, ey};
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    map_q <= map_mem[map_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clr_wr) clr_cnt <= clr_cnt + AW'(1);
  end

  // Decay: magnitude times persistence, truncated, sign restored.
  logic signed [OW-1:0] e_x, e_y;
  logic [OW-1:0]        mag_x, mag_y, q_x, q_y;
  logic [PW-1:0]        prod_x, prod_y;
  logic                 sgn_x, sgn_y;

  assign e_x   = en_clr ? '0 : map_q[2*OW-1:OW];
  assign e_y   = en_clr ? '0 : map_q[OW-1:0];
  assign mag_x = e_x[OW-1] ? -e_x : e_x;
  assign mag_y = e_y[OW-1] ? -e_y : e_y;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      sgn_x  <= e_x[OW-1];
      sgn_y  <= e_y[OW-1];
      prod_x <= PW'(mag_x) * PW'(p_eff);
      prod_y <= PW'(mag_y) * PW'(p_eff);
    end
  end

  assign q_x = prod_x[OW+15:16];
  assign q_y = prod_y[OW+15:16];
  assign ex  = sgn_x ? -q_x : q_x;
  assign ey  = sgn_y ? -q_y : q_y;

  // Displaced coordinate, integer part truncated toward zero.
  logic signed [CW-1:0] c_x, c_y;
  logic [CW-1:0]        m_x, m_y;

  assign c_x    = $signed(CW'(px_q) << F) + CW'(ex);
  assign c_y    = $signed(CW'(py_q) << F) + CW'(ey);
  assign cneg_x = c_x[CW-1];
  assign cneg_y = c_y[CW-1];
  assign m_x    = cneg_x ? -c_x : c_x;
  assign m_y    = cneg_y ? -c_y : c_y;
  assign cmag_x = m_x[CW-1:F];
  assign cmag_y = m_y[CW-1:F];

  // Source frame.
  logic [rdw_pkg::PIX_W-1:0] frame_mem [DEPTH];
  logic [rdw_pkg::PIX_W-1:0] frame_q;

  always_ff @(posedge clk) begin
    if (cmd.frame_wr) frame_mem[idx_q] <= pix_q;
    frame_q <= frame_mem[addr_of(rx, ry)];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) pixel_out <= frame_q;
  end

  assign status.mod_done  = !busy_x && !busy_y;
  assign status.clr_last  = (clr_cnt == AW'(DEPTH - 1));
  assign status.cell_last = col_last && row_last;
  assign status.rect_skip = skip_q;
  assign status.out_free  = !out_valid || !out_stall;
  assign status.op        = op_q;

endmodule

// ----- rtl/core/rdw_ctrl.sv -----
// ----------------------------------------------------------------------------
// rdw_ctrl
// Sequencer for map clearing, loads, rectangle walks and renders.
// ----------------------------------------------------------------------------
module rdw_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rdw_pkg::rdw_status_t status,
  output rdw_pkg::rdw_cmd_t    cmd
);

  typedef enum logic [11:0] {
    S_CLEAR = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_START = 12'b000000000100,
    S_WAITP = 12'b000000001000,
    S_LOAD  = 12'b000000010000,
    S_CRD   = 12'b000000100000,
    S_CWR   = 12'b000001000000,
    S_MRD   = 12'b000010000000,
    S_MUL   = 12'b000100000000,
    S_DEC   = 12'b001000000000,
    S_WAITC = 12'b010000000000,
    S_PUSH  = 12'b100000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_START;
        end
      end
      S_START: begin
        cmd.start_pos = 1'b1;
        state_next    = S_WAITP;
      end
      S_WAITP: begin
        if (status.mod_done) begin
          cmd.latch_pos = 1'b1;
          unique case (status.op)
            rdw_pkg::OP_LOAD:   state_next = S_LOAD;
            rdw_pkg::OP_RECT:   state_next = status.rect_skip ? S_IDLE : S_CRD;
            rdw_pkg::OP_RENDER: state_next = S_MRD;
            default:            state_next = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        cmd.frame_wr = 1'b1;
        state_next   = S_IDLE;
      end
      S_CRD: begin
        cmd.map_rd_cell = 1'b1;
        state_next      = S_CWR;
      end
      S_CWR: begin
        cmd.map_wr_cell = 1'b1;
        state_next      = status.cell_last ? S_IDLE : S_CRD;
      end
      S_MRD: begin
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DEC;
      end
      S_DEC: begin
        cmd.dec    = 1'b1;
        state_next = S_WAITC;
      end
      S_WAITC: begin
        if (status.mod_done) state_next = S_PUSH;
      end
      S_PUSH: begin
        if (status.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
